/* rtl/lrpe_pkg.sv */
// Shared constants, command/status types and address helpers for the LR parse engine.
// Used by the controller, the datapath, the top level and the port checker.
package lrpe_pkg;

  // Table and stack sizes.
  localparam int STATES       = 256;
  localparam int SYMBOLS      = 64;
  localparam int RULES        = 64;
  localparam int STACK_DEPTH  = 64;
  localparam int REDUCE_LIMIT = 64;

  localparam int ACT_DEPTH = STATES * SYMBOLS;
  localparam int ACT_AW    = $clog2(ACT_DEPTH);
  localparam int RULE_AW   = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int STK_AW    = $clog2(STACK_DEPTH);
  localparam int TOP_W     = $clog2(STACK_DEPTH + 1);

  // Field widths.
  localparam int OP_W   = 2;
  localparam int ST_W   = 8;
  localparam int SYM_W  = 6;
  localparam int KIND_W = 3;
  localparam int TGT_W  = 8;
  localparam int RIDX_W = 6;
  localparam int LEN_W  = 4;
  localparam int LHS_W  = 6;
  localparam int STAT_W = 2;
  localparam int RED_W  = 8;
  localparam int ACT_DW = KIND_W + TGT_W;
  localparam int RULE_DW = LEN_W + LHS_W;

  // Request operations.
  localparam logic [OP_W-1:0] OP_WRITE_ACTION = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_RULE   = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART      = 2'd2;
  localparam logic [OP_W-1:0] OP_FEED         = 2'd3;

  // Action entry kinds.
  localparam logic [KIND_W-1:0] KIND_REJECT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SHIFT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REDUCE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_GOTO   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ACCEPT = 3'd4;

  // Result status codes; the first three double as the parse outcome.
  localparam logic [STAT_W-1:0] ST_SHIFTED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_ACCEPTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_REJECTED = 2'd2;
  localparam logic [STAT_W-1:0] ST_ACK      = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              capture;
    logic              clear_step;
    logic              act_write;
    logic              rule_write;
    logic              restart;
    logic              red_clear;
    logic              rd_act_cur;
    logic              rd_act_goto;
    logic              rd_rule;
    logic              rd_stack;
    logic              push_shift;
    logic              push_goto;
    logic              decide;
    logic [STAT_W-1:0] dec_outcome;
    logic              dec_fault;
    logic              out_load;
  } lrpe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic              clear_last;
    logic [OP_W-1:0]   op;
    logic              running;
    logic [KIND_W-1:0] act_kind;
    logic              target_ok;
    logic              red_at_limit;
    logic              stack_full;
    logic              len_underflow;
    logic              newtop_full;
    logic              out_free;
  } lrpe_stat_t;

  // Flat action table address of a state row and symbol column.
  function automatic logic [ACT_AW-1:0] act_addr(input logic [ST_W-1:0] st,
                                                 input logic [SYM_W-1:0] sym);
    return ACT_AW'(st) * ACT_AW'(SYMBOLS) + ACT_AW'(sym);
  endfunction

  // True when the state and symbol fall inside the table.
  function automatic logic act_in_range(input logic [ST_W-1:0] st,
                                        input logic [SYM_W-1:0] sym);
    return (32'(st) < STATES) && (32'(sym) < SYMBOLS);
  endfunction

endpackage

/* rtl/lrpe_ctrl.sv */
// Sequencer of the LR parse engine: table clearing, request dispatch and the
// reduce/goto loop. Depends on lrpe_pkg; drives the datapath by lrpe_cmd_t.
module lrpe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lrpe_pkg::lrpe_stat_t stat,
  output lrpe_pkg::lrpe_cmd_t  cmd
);
  import lrpe_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_FETCH = 4'd3;
  localparam logic [3:0] S_ACT   = 4'd4;
  localparam logic [3:0] S_RULE  = 4'd5;
  localparam logic [3:0] S_STK   = 4'd6;
  localparam logic [3:0] S_GOTO  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_r, state_nxt;

  // A new request is taken only while the sequencer waits in idle.
  assign in_stall = (state_r != S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        unique case (stat.op)
          OP_WRITE_ACTION: cmd.act_write  = 1'b1;
          OP_WRITE_RULE:   cmd.rule_write = 1'b1;
          OP_RESTART:      cmd.restart    = 1'b1;
          OP_FEED: begin
            // A decided parse just repeats its latched result.
            if (stat.running) begin
              cmd.red_clear = 1'b1;
              state_nxt     = S_FETCH;
            end
          end
          default: ;
        endcase
      end
      S_FETCH: begin
        cmd.rd_act_cur = 1'b1;
        state_nxt      = S_ACT;
      end
      S_ACT: begin
        state_nxt = S_DONE;
        unique case (stat.act_kind)
          KIND_SHIFT: begin
            if (stat.stack_full) begin
              cmd.decide      = 1'b1;
              cmd.dec_outcome = ST_REJECTED;
              cmd.dec_fault   = 1'b1;
            end else begin
              cmd.push_shift = 1'b1;
            end
          end
          KIND_ACCEPT: begin
            cmd.decide      = 1'b1;
            cmd.dec_outcome = ST_ACCEPTED;
          end
          KIND_REDUCE: begin
            if (!stat.target_ok) begin
              cmd.decide      = 1'b1;
              cmd.dec_outcome = ST_REJECTED;
            end else if (stat.red_at_limit) begin
              cmd.decide      = 1'b1;
              cmd.dec_outcome = ST_REJECTED;
              cmd.dec_fault   = 1'b1;
            end else begin
              cmd.rd_rule = 1'b1;
              state_nxt   = S_RULE;
            end
          end
          default: begin
            cmd.decide      = 1'b1;
            cmd.dec_outcome = ST_REJECTED;
          end
        endcase
      end
      S_RULE: begin
        // Pop the rule length; running out of stack, or a full stack left for the goto push, is a fault.
        if (stat.len_underflow || stat.newtop_full) begin
          cmd.decide      = 1'b1;
          cmd.dec_outcome = ST_REJECTED;
          cmd.dec_fault   = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          cmd.rd_stack = 1'b1;
          state_nxt    = S_STK;
        end
      end
      S_STK: begin
        cmd.rd_act_goto = 1'b1;
        state_nxt       = S_GOTO;
      end
      S_GOTO: begin
        if (stat.act_kind == KIND_GOTO) begin
          cmd.push_goto = 1'b1;
          state_nxt     = S_FETCH;
        end else begin
          cmd.decide      = 1'b1;
          cmd.dec_outcome = ST_REJECTED;
          state_nxt       = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

/* rtl/lrpe_dpath.sv */
// Datapath of the LR parse engine: action, rule and stack memories, stack
// pointer, reduction count, latched outcome and the result register. Uses lrpe_pkg.
module lrpe_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lrpe_pkg::lrpe_cmd_t           cmd,
  output lrpe_pkg::lrpe_stat_t          stat,
  input  logic [lrpe_pkg::OP_W-1:0]     in_operation,
  input  logic [lrpe_pkg::ST_W-1:0]     in_state_index,
  input  logic [lrpe_pkg::SYM_W-1:0]    in_symbol,
  input  logic [lrpe_pkg::KIND_W-1:0]   in_action_kind,
  input  logic [lrpe_pkg::TGT_W-1:0]    in_action_target,
  input  logic [lrpe_pkg::RIDX_W-1:0]   in_rule_index,
  input  logic [lrpe_pkg::LEN_W-1:0]    in_rule_length,
  input  logic [lrpe_pkg::LHS_W-1:0]    in_rule_lhs,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lrpe_pkg::STAT_W-1:0]   out_status,
  output logic [lrpe_pkg::RED_W-1:0]    out_reductions,
  output logic                          out_stack_fault
);
  import lrpe_pkg::*;

  // Captured request.
  logic [OP_W-1:0]   op_r;
  logic [ST_W-1:0]   st_r;
  logic [SYM_W-1:0]  sym_r;
  logic [KIND_W-1:0] kind_r;
  logic [TGT_W-1:0]  tgt_r;
  logic [RIDX_W-1:0] ridx_r;
  logic [LEN_W-1:0]  len_r;
  logic [LHS_W-1:0]  lhs_r;

  // Memories and their registered read data.
  logic [ACT_DW-1:0]  act_mem [ACT_DEPTH];
  logic [RULE_DW-1:0] rule_mem [RULES];
  logic [TGT_W-1:0]   stk_mem [STACK_DEPTH];
  logic [ACT_DW-1:0]  act_rdata_r;
  logic               act_ok_r;
  logic [RULE_DW-1:0] rule_rdata_r;
  logic [TGT_W-1:0]   stk_rdata_r;

  // Parse state.
  logic [ACT_AW-1:0] clr_cnt_r;
  logic [TOP_W-1:0]  top_r;
  logic [TGT_W-1:0]  tos_r;
  logic [RED_W-1:0]  red_r;
  logic [STAT_W-1:0] outcome_r;
  logic [RED_W-1:0]  lat_red_r;
  logic              lat_fault_r;

  // Result register.
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [RED_W-1:0]  out_red_r;
  logic              out_fault_r;

  // Decoded read data.
  logic [KIND_W-1:0] act_kind;
  logic [TGT_W-1:0]  act_tgt;
  logic [LEN_W-1:0]  rd_len;
  logic [LHS_W-1:0]  rd_lhs;
  logic [TOP_W-1:0]  newtop;

  // An out-of-range lookup reads as a reject entry.
  assign act_kind = act_ok_r ? act_rdata_r[ACT_DW-1:TGT_W] : KIND_REJECT;
  assign act_tgt  = act_ok_r ? act_rdata_r[TGT_W-1:0] : '0;
  assign rd_len   = rule_rdata_r[RULE_DW-1:LHS_W];
  assign rd_lhs   = rule_rdata_r[LHS_W-1:0];
  assign newtop   = top_r - TOP_W'(rd_len);

  // Status toward the controller.
  always_comb begin
    stat.clear_last    = (clr_cnt_r == ACT_AW'(ACT_DEPTH - 1));
    stat.op            = op_r;
    stat.running       = (outcome_r == ST_SHIFTED);
    stat.act_kind      = act_kind;
    stat.target_ok     = (32'(act_tgt) < RULES);
    stat.red_at_limit  = (32'(red_r) >= REDUCE_LIMIT);
    stat.stack_full    = (32'(top_r) >= STACK_DEPTH);
    stat.len_underflow = (32'(rd_len) >= 32'(top_r));
    stat.newtop_full   = (32'(newtop) >= STACK_DEPTH);
    stat.out_free      = !out_valid_r || !out_stall;
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_operation;
      st_r   <= in_state_index;
      sym_r  <= in_symbol;
      kind_r <= in_action_kind;
      tgt_r  <= in_action_target;
      ridx_r <= in_rule_index;
      len_r  <= in_rule_length;
      lhs_r  <= in_rule_lhs;
    end
  end

  // Action memory: one write port (clear pass or table load), one read port.
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      act_mem[clr_cnt_r] <= '0;
    end else if (cmd.act_write && act_in_range(st_r, sym_r)) begin
      act_mem[act_addr(st_r, sym_r)] <= {kind_r, tgt_r};
    end
    if (cmd.rd_act_cur) begin
      act_rdata_r <= act_mem[act_addr(tos_r, sym_r)];
      act_ok_r    <= act_in_range(tos_r, sym_r);
    end else if (cmd.rd_act_goto) begin
      act_rdata_r <= act_mem[act_addr(stk_rdata_r, rd_lhs)];
      act_ok_r    <= act_in_range(stk_rdata_r, rd_lhs);
    end
  end

  // Rule memory holds length and left side of each rule.
  always_ff @(posedge clk) begin
    if (cmd.rule_write && (32'(ridx_r) < RULES)) begin
      rule_mem[RULE_AW'(ridx_r)] <= {len_r, lhs_r};
    end
    if (cmd.rd_rule) begin
      rule_rdata_r <= rule_mem[RULE_AW'(act_tgt)];
    end
  end

  // Stack memory; the bottom entry is set to state 0 during the clear pass.
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      stk_mem[0] <= '0;
    end else if (cmd.push_shift || cmd.push_goto) begin
      stk_mem[STK_AW'(top_r)] <= act_tgt;
    end
    if (cmd.rd_stack) begin
      stk_rdata_r <= stk_mem[STK_AW'(newtop - TOP_W'(1))];
    end
  end

  // Stack pointer, top-of-stack copy, reduction count and latched outcome.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      top_r       <= TOP_W'(1);
      tos_r       <= '0;
      red_r       <= '0;
      outcome_r   <= ST_SHIFTED;
      lat_red_r   <= '0;
      lat_fault_r <= 1'b0;
    end else begin
      if (cmd.clear_step) clr_cnt_r <= clr_cnt_r + ACT_AW'(1);
      if (cmd.restart) begin
        top_r       <= TOP_W'(1);
        tos_r       <= '0;
        outcome_r   <= ST_SHIFTED;
        lat_red_r   <= '0;
        lat_fault_r <= 1'b0;
      end
      if (cmd.red_clear) red_r <= '0;
      if (cmd.rd_stack) top_r <= newtop;
      if (cmd.push_shift || cmd.push_goto) begin
        top_r <= top_r + TOP_W'(1);
        tos_r <= act_tgt;
      end
      if (cmd.push_goto) red_r <= red_r + RED_W'(1);
      if (cmd.push_shift) begin
        lat_red_r   <= red_r;
        lat_fault_r <= 1'b0;
      end
      if (cmd.decide) begin
        outcome_r   <= cmd.dec_outcome;
        lat_red_r   <= red_r;
        lat_fault_r <= cmd.dec_fault;
      end
    end
  end

  // Result register: a feed reports the latched outcome, all else an acknowledgement.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (op_r == OP_FEED) begin
        out_status_r <= outcome_r;
        out_red_r    <= lat_red_r;
        out_fault_r  <= lat_fault_r;
      end else begin
        out_status_r <= ST_ACK;
        out_red_r    <= '0;
        out_fault_r  <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_reductions  = out_red_r;
  assign out_stack_fault = out_fault_r;

endmodule

/* rtl/lr_table_parse_engine_core.sv */
// Top level of the table-driven LR(1) parse engine: sequencer plus datapath.
// Depends on lrpe_pkg, lrpe_ctrl and lrpe_dpath.
//
// Each request gives one result. After reset the engine sweeps the action
// table to reject, one entry a cycle (all STATES*SYMBOLS = 16384 entries),
// and holds in_stall high until that is done. A table write, a restart or a
// feed after the parse is decided then goes from idle through the execute
// and done states. A fed symbol also passes the fetch and action states; each
// reduction it triggers goes on through the rule, stack and goto states and
// back to fetch, walking the single action-memory port twice (action, then
// goto) with the rule and stack reads between them, each a registered read.
// A rejection found after the rule read (stack underflow or overflow) is
// decided in the rule state, one found at the goto read in the goto state.
// A finished result sits in the output register while the next request is
// already being worked; only the hand-off of a new result waits for it, so
// a stalled result holds up the request behind it in the done state.
module lr_table_parse_engine_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lrpe_pkg::OP_W-1:0]     in_operation,
  input  logic [lrpe_pkg::ST_W-1:0]     in_state_index,
  input  logic [lrpe_pkg::SYM_W-1:0]    in_symbol,
  input  logic [lrpe_pkg::KIND_W-1:0]   in_action_kind,
  input  logic [lrpe_pkg::TGT_W-1:0]    in_action_target,
  input  logic [lrpe_pkg::RIDX_W-1:0]   in_rule_index,
  input  logic [lrpe_pkg::LEN_W-1:0]    in_rule_length,
  input  logic [lrpe_pkg::LHS_W-1:0]    in_rule_lhs,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lrpe_pkg::STAT_W-1:0]   out_status,
  output logic [lrpe_pkg::RED_W-1:0]    out_reductions,
  output logic                          out_stack_fault
);
  import lrpe_pkg::*;

  lrpe_cmd_t  cmd;
  lrpe_stat_t stat;

  // Sequencer.
  lrpe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Memories, stack and result register.
  lrpe_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_operation     (in_operation),
    .in_state_index   (in_state_index),
    .in_symbol        (in_symbol),
    .in_action_kind   (in_action_kind),
    .in_action_target (in_action_target),
    .in_rule_index    (in_rule_index),
    .in_rule_length   (in_rule_length),
    .in_rule_lhs      (in_rule_lhs),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_reductions   (out_reductions),
    .out_stack_fault  (out_stack_fault)
  );

endmodule

/* rtl/lrpe_checker.sv */
// Port-level checks of the LR parse engine, bound to its top level.
// Depends on lrpe_pkg and lr_table_parse_engine_core.
module lrpe_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [lrpe_pkg::STAT_W-1:0] out_status,
  input logic [lrpe_pkg::RED_W-1:0]  out_reductions,
  input logic                        out_stack_fault
);
  import lrpe_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_reductions) && $stable(out_stack_fault))
    else $error("stalled result changed");

  // A fault flag only comes with a rejection.
  a_fault_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stack_fault |-> out_status == ST_REJECTED)
    else $error("stack fault without rejection");

  // Acknowledgements carry no count and no fault.
  a_ack_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_ACK |-> out_reductions == '0 && !out_stack_fault)
    else $error("acknowledgement with reductions or fault");

  // The reduction count never passes the limit.
  a_red_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_reductions) <= REDUCE_LIMIT)
    else $error("reduction count above limit");

  // The engine is busy in the cycle after it takes a request.
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken on two consecutive cycles");

endmodule

bind lr_table_parse_engine_core lrpe_checker u_lrpe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_reductions  (out_reductions),
  .out_stack_fault (out_stack_fault)
);

/* bench/tb_top.sv */
// Self-checking testbench for the LR(1) table parse engine core.
// Depends on lrpe_pkg and lr_table_parse_engine_core; a directed script is followed by
// randomly built grammar tables whose parses are checked against an in-bench parser.
module tb_top;
  import lrpe_pkg::*;

  localparam int END_MARK       = 26;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int QUIET_FROM     = 1020;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int DRAIN_CYCLES   = 400;
  localparam int MAX_REPORTS    = 10;
  // Highest kind code, one of the undefined ones.
  localparam logic [KIND_W-1:0] KIND_TOP = '1;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ST_W-1:0]   st;
    logic [SYM_W-1:0]  sym;
    logic [KIND_W-1:0] kind;
    logic [TGT_W-1:0]  tgt;
    logic [RIDX_W-1:0] ridx;
    logic [LEN_W-1:0]  len;
    logic [LHS_W-1:0]  lhs;
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [RED_W-1:0]  reds;
    logic              fault;
  } outcome_t;

  typedef struct packed {
    request_t req;
    logic     typed;
    outcome_t want;
  } script_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_operation = '0;
  logic [ST_W-1:0]     in_state_index = '0;
  logic [SYM_W-1:0]    in_symbol = '0;
  logic [KIND_W-1:0]   in_action_kind = '0;
  logic [TGT_W-1:0]    in_action_target = '0;
  logic [RIDX_W-1:0]   in_rule_index = '0;
  logic [LEN_W-1:0]    in_rule_length = '0;
  logic [LHS_W-1:0]    in_rule_lhs = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STAT_W-1:0]   out_status;
  logic [RED_W-1:0]    out_reductions;
  logic                out_stack_fault;

  lr_table_parse_engine_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_state_index   (in_state_index),
    .in_symbol        (in_symbol),
    .in_action_kind   (in_action_kind),
    .in_action_target (in_action_target),
    .in_rule_index    (in_rule_index),
    .in_rule_length   (in_rule_length),
    .in_rule_lhs      (in_rule_lhs),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_reductions   (out_reductions),
    .out_stack_fault  (out_stack_fault)
  );

  // Free-running clock, period 2.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Parser copy kept by the bench: tables, state stack and the latched decision.
  logic [ACT_DW-1:0] act_tab [ACT_DEPTH];
  logic [LEN_W-1:0]  rule_len_tab [RULES];
  logic [LHS_W-1:0]  rule_lhs_tab [RULES];
  logic [ST_W-1:0]   state_stack [STACK_DEPTH];
  int                depth;
  logic [STAT_W-1:0] verdict;     // ST_SHIFTED while the parse is still running
  logic [RED_W-1:0]  held_reds;
  logic              held_fault;

  // Rules written so far; reduce entries only ever name these.
  bit                rule_known [RULES];

  outcome_t          pending_results [$];
  script_row_t       script [$];
  int                fail_count = 0;
  int                sent = 0;
  int                quiet_cycles = 0;
  int                stall_left = 0;
  bit                calm = 1'b0;
  bit                quiet = 1'b0;

  // Append one row to the directed script.
  function automatic void add_row(input script_row_t row);
    script.insert(script.size(), row);
  endfunction

  // Queue the result that an accepted request should give.
  function automatic void expect_result(input outcome_t o);
    pending_results.insert(pending_results.size(), o);
  endfunction

  function automatic void restart_parse();
    foreach (state_stack[i]) state_stack[i] = '0;
    depth      = 1;
    verdict    = ST_SHIFTED;
    held_reds  = '0;
    held_fault = 1'b0;
  endfunction

  function automatic logic [ACT_DW-1:0] lookup(input logic [ST_W-1:0] s,
                                               input logic [SYM_W-1:0] c);
    if (int'(s) >= STATES || int'(c) >= SYMBOLS) return '0;
    return act_tab[int'(s) * SYMBOLS + int'(c)];
  endfunction

  function automatic void settle(input logic [STAT_W-1:0] v, input int red, input logic f);
    verdict    = v;
    held_reds  = (red > 255) ? 8'd255 : RED_W'(red);
    held_fault = f;
  endfunction

  // Reduce on a fed terminal until it is shifted, accepted or rejected.
  function automatic void consume_symbol(input logic [SYM_W-1:0] sym);
    int                red;
    int                len;
    bit                done;
    logic [ACT_DW-1:0] ent;
    logic [ACT_DW-1:0] go;
    logic [KIND_W-1:0] kind;
    logic [TGT_W-1:0]  tgt;
    red  = 0;
    done = 1'b0;
    while (!done) begin
      ent  = lookup(state_stack[depth-1], sym);
      kind = ent[ACT_DW-1:TGT_W];
      tgt  = ent[TGT_W-1:0];
      done = 1'b1;
      if (kind == KIND_SHIFT) begin
        if (depth >= STACK_DEPTH) begin
          settle(ST_REJECTED, red, 1'b1);
        end else begin
          state_stack[depth] = tgt;
          depth++;
          settle(ST_SHIFTED, red, 1'b0);
        end
      end else if (kind == KIND_ACCEPT) begin
        settle(ST_ACCEPTED, red, 1'b0);
      end else if (kind != KIND_REDUCE || int'(tgt) >= RULES) begin
        settle(ST_REJECTED, red, 1'b0);
      end else if (red >= REDUCE_LIMIT) begin
        settle(ST_REJECTED, red, 1'b1);
      end else begin
        len = int'(rule_len_tab[tgt[RIDX_W-1:0]]);
        if (len >= depth) begin
          settle(ST_REJECTED, red, 1'b1);
        end else begin
          depth -= len;
          if (depth >= STACK_DEPTH) begin
            settle(ST_REJECTED, red, 1'b1);
          end else begin
            go = lookup(state_stack[depth-1], rule_lhs_tab[tgt[RIDX_W-1:0]]);
            if (go[ACT_DW-1:TGT_W] != KIND_GOTO) begin
              settle(ST_REJECTED, red, 1'b0);
            end else begin
              state_stack[depth] = go[TGT_W-1:0];
              depth++;
              red++;
              done = 1'b0;
            end
          end
        end
      end
    end
  endfunction

  // Apply one accepted request to the parser copy and return the result it gives.
  function automatic outcome_t advance_parser(input request_t r);
    outcome_t o;
    o.status = ST_ACK;
    o.reds   = '0;
    o.fault  = 1'b0;
    case (r.op)
      OP_WRITE_ACTION: begin
        if (int'(r.st) < STATES && int'(r.sym) < SYMBOLS)
          act_tab[int'(r.st) * SYMBOLS + int'(r.sym)] = {r.kind, r.tgt};
      end
      OP_WRITE_RULE: begin
        if (int'(r.ridx) < RULES) begin
          rule_len_tab[r.ridx] = r.len;
          rule_lhs_tab[r.ridx] = r.lhs;
        end
      end
      OP_RESTART: begin
        restart_parse();
      end
      default: begin
        if (verdict == ST_SHIFTED) consume_symbol(r.sym);
        o.status = verdict;
        o.reds   = held_reds;
        o.fault  = held_fault;
      end
    endcase
    return o;
  endfunction

  // Request builders; fields the operation ignores carry random values.
  function automatic request_t noise_req();
    logic [63:0] bits;
    request_t    r;
    bits = {$urandom, $urandom};
    r = bits[$bits(request_t)-1:0];
    return r;
  endfunction

  function automatic request_t act_w(input int s, input int c, input logic [KIND_W-1:0] k,
                                     input int t);
    request_t r;
    r      = noise_req();
    r.op   = OP_WRITE_ACTION;
    r.st   = ST_W'(s);
    r.sym  = SYM_W'(c);
    r.kind = k;
    r.tgt  = TGT_W'(t);
    return r;
  endfunction

  function automatic request_t rule_w(input int idx, input int len, input int lhs);
    request_t r;
    r      = noise_req();
    r.op   = OP_WRITE_RULE;
    r.ridx = RIDX_W'(idx);
    r.len  = LEN_W'(len);
    r.lhs  = LHS_W'(lhs);
    return r;
  endfunction

  function automatic request_t restart_req();
    request_t r;
    r    = noise_req();
    r.op = OP_RESTART;
    return r;
  endfunction

  function automatic request_t feed_req(input int c);
    request_t r;
    r     = noise_req();
    r.op  = OP_FEED;
    r.sym = SYM_W'(c);
    return r;
  endfunction

  function automatic script_row_t row_of(input request_t r, input logic typed,
                                         input logic [STAT_W-1:0] s, input int red,
                                         input logic f);
    script_row_t row;
    row.req         = r;
    row.typed       = typed;
    row.want.status = s;
    row.want.reds   = RED_W'(red);
    row.want.fault  = f;
    return row;
  endfunction

  // Mostly a state of the small grammar, now and then any state.
  function automatic int pick_state(input int n);
    return ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, n - 1);
  endfunction

  // Drive one request, wait for its acceptance and queue the result it should give.
  task automatic send(input request_t req, input logic typed, input outcome_t want);
    request_t r;
    outcome_t got;
    r = req;
    // Never let a reduce entry name a rule that has not been written.
    if (r.op == OP_WRITE_ACTION && r.kind == KIND_REDUCE && int'(r.tgt) < RULES &&
        !rule_known[r.tgt[RIDX_W-1:0]])
      r.tgt[TGT_W-1] = 1'b1;
    if (r.op == OP_WRITE_RULE) rule_known[r.ridx] = 1'b1;

    if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 16)) @(negedge clk);
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_operation     <= r.op;
    in_state_index   <= r.st;
    in_symbol        <= r.sym;
    in_action_kind   <= r.kind;
    in_action_target <= r.tgt;
    in_rule_index    <= r.ridx;
    in_rule_length   <= r.len;
    in_rule_lhs      <= r.lhs;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    got = advance_parser(r);
    expect_result(typed ? want : got);
    sent++;
  endtask

  // Result side stalls in bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 16);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each result with the oldest expectation and watch for a hang.
  always @(posedge clk) begin : check_results
    outcome_t want;
    bit       in_fire;
    bit       out_fire;
    in_fire  = (in_valid === 1'b1) && (in_stall === 1'b0);
    out_fire = (rst_n === 1'b1) && (out_valid === 1'b1) && (out_stall === 1'b0);
    if (out_fire) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: result with no request pending: status %0d reductions %0d fault %0b",
                   $time, out_status, out_reductions, out_stack_fault);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_reductions !== want.reds ||
            out_stack_fault !== want.fault) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: mismatch: status %0d (exp %0d) reductions %0d (exp %0d) fault %0b (exp %0b)",
                     $time, out_status, want.status, out_reductions, want.reds,
                     out_stack_fault, want.fault);
        end
      end
    end
    if (in_fire || out_fire) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus: directed script, then random grammar phases.
  initial begin
    request_t    r;
    logic [KIND_W-1:0] kind;
    int          tgt;
    int          w;
    int          n_states;
    int          n_rules;
    int          runs;
    int          steps;
    int          max_steps;
    int          term [4];
    int          nterm [2];
    int          rule_id [4];
    bit          deep;

    foreach (act_tab[i]) act_tab[i] = '0;
    foreach (rule_len_tab[i]) rule_len_tab[i] = '0;
    foreach (rule_lhs_tab[i]) rule_lhs_tab[i] = '0;
    foreach (rule_known[i]) rule_known[i] = 1'b0;
    restart_parse();

    // Goto kind met for a fed symbol, straight after reset.
    add_row(row_of(act_w(0, 5, KIND_GOTO, 9), 1'b1, ST_ACK, 0, 1'b0));
    add_row(row_of(feed_req(5), 1'b1, ST_REJECTED, 0, 1'b0));
    // Shift then accept; a later feed repeats the decision.
    add_row(row_of(act_w(0, 0, KIND_SHIFT, 1), 1'b1, ST_ACK, 0, 1'b0));
    add_row(row_of(act_w(1, END_MARK, KIND_ACCEPT, 0), 1'b1, ST_ACK, 0, 1'b0));
    add_row(row_of(rule_w(0, 1, 30), 1'b1, ST_ACK, 0, 1'b0));
    add_row(row_of(act_w(1, 1, KIND_REDUCE, 0), 1'b1, ST_ACK, 0, 1'b0));
    add_row(row_of(act_w(0, 30, KIND_GOTO, 1), 1'b1, ST_ACK, 0, 1'b0));
    add_row(row_of(restart_req(), 1'b1, ST_ACK, 0, 1'b0));
    add_row(row_of(feed_req(0), 1'b1, ST_SHIFTED, 0, 1'b0));
    add_row(row_of(feed_req(END_MARK), 1'b1, ST_ACCEPTED, 0, 1'b0));
    add_row(row_of(feed_req(63), 1'b1, ST_ACCEPTED, 0, 1'b0));
    // Endless reduce loop runs into the reduction limit.
    add_row(row_of(restart_req(), 1'b1, ST_ACK, 0, 1'b0));
    add_row(row_of(feed_req(0), 1'b1, ST_SHIFTED, 0, 1'b0));
    add_row(row_of(feed_req(1), 1'b0, ST_ACK, 0, 1'b0));
    // Stack underflow with the longest rule at the top rule index.
    add_row(row_of(rule_w(RULES - 1, 15, 63), 1'b1, ST_ACK, 0, 1'b0));
    add_row(row_of(act_w(0, 2, KIND_REDUCE, RULES - 1), 1'b1, ST_ACK, 0, 1'b0));
    add_row(row_of(restart_req(), 1'b1, ST_ACK, 0, 1'b0));
    add_row(row_of(feed_req(2), 1'b1, ST_REJECTED, 0, 1'b1));
    // Undefined kind with the largest target.
    add_row(row_of(act_w(0, 3, KIND_TOP, 255), 1'b1, ST_ACK, 0, 1'b0));
    add_row(row_of(restart_req(), 1'b1, ST_ACK, 0, 1'b0));
    add_row(row_of(feed_req(3), 1'b1, ST_REJECTED, 0, 1'b0));
    // Reduce naming a rule past the rule table.
    add_row(row_of(act_w(0, 4, KIND_REDUCE, 255), 1'b1, ST_ACK, 0, 1'b0));
    add_row(row_of(restart_req(), 1'b1, ST_ACK, 0, 1'b0));
    add_row(row_of(feed_req(4), 1'b1, ST_REJECTED, 0, 1'b0));
    // Reduce whose goto entry is missing.
    add_row(row_of(rule_w(1, 0, 29), 1'b1, ST_ACK, 0, 1'b0));
    add_row(row_of(act_w(0, 6, KIND_REDUCE, 1), 1'b1, ST_ACK, 0, 1'b0));
    add_row(row_of(restart_req(), 1'b1, ST_ACK, 0, 1'b0));
    add_row(row_of(feed_req(6), 1'b0, ST_ACK, 0, 1'b0));

    // Synchronous reset, released at a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) send(script[i].req, script[i].typed, script[i].want);

    // Each phase loads a small random grammar and then parses with it.
    while (sent - script.size() < RANDOM_ITEMS) begin
      quiet = (sent - script.size() >= QUIET_FROM);
      calm  = ($urandom_range(0, 3) == 0);

      // Hold off new requests until every outstanding result has come back.
      @(negedge clk);
      in_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);

      n_states = $urandom_range(2, 8);
      deep     = ($urandom_range(0, 3) == 0);
      term[0]  = $urandom_range(0, END_MARK - 1);
      term[1]  = (term[0] + $urandom_range(1, 8)) % END_MARK;
      term[2]  = (term[1] + $urandom_range(1, 8)) % END_MARK;
      term[3]  = END_MARK;
      nterm[0] = $urandom_range(END_MARK + 1, SYMBOLS - 1);
      nterm[1] = $urandom_range(END_MARK + 1, SYMBOLS - 1);

      // Rule table entries, mostly short rules on the phase's nonterminals.
      n_rules = $urandom_range(1, 4);
      for (int k = 0; k < n_rules; k++) begin
        rule_id[k] = $urandom_range(0, RULES - 1);
        send(rule_w(rule_id[k],
                    ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                : nterm[$urandom_range(0, 1)]),
             1'b0, '0);
      end

      // Terminal columns; in a deep phase the first terminal always shifts.
      for (int s = 0; s < n_states; s++) begin
        for (int t = 0; t < 4; t++) begin
          w   = $urandom_range(0, 99);
          tgt = $urandom_range(0, 255);
          if ((deep && t == 0) || w < 40) begin
            kind = KIND_SHIFT;
            tgt  = pick_state(n_states);
          end else if (w < 70) begin
            kind = KIND_REDUCE;
            tgt  = ($urandom_range(0, 11) == 0) ? $urandom_range(RULES, 255)
                                                 : rule_id[$urandom_range(0, n_rules - 1)];
          end else if (w < 80) begin
            kind = KIND_ACCEPT;
          end else if (w < 90) begin
            kind = KIND_REJECT;
          end else if ($urandom_range(0, 1) == 0) begin
            kind = KIND_GOTO;
          end else begin
            kind = KIND_W'($urandom_range(int'(KIND_ACCEPT) + 1, int'(KIND_TOP)));
          end
          send(act_w(s, term[t], kind, tgt), 1'b0, '0);
        end
      end

      // Nonterminal columns: mostly goto entries, a few left rejecting.
      for (int n = 0; n < 2; n++) begin
        for (int s = 0; s < n_states; s++) begin
          if ($urandom_range(0, 7) != 0)
            send(act_w(s, nterm[n], KIND_GOTO, pick_state(n_states)), 1'b0, '0);
          else
            send(act_w(s, nterm[n], KIND_REJECT, $urandom_range(0, 255)), 1'b0, '0);
        end
      end

      // Parse runs; now and then the restart is left out or noise is mixed in.
      runs = $urandom_range(2, 6);
      for (int k = 0; k < runs && sent - script.size() < RANDOM_ITEMS; k++) begin
        if ($urandom_range(0, 7) != 0) send(restart_req(), 1'b0, '0);
        max_steps = deep ? 75 : $urandom_range(1, 40);
        steps = 0;
        while (verdict == ST_SHIFTED && steps < max_steps) begin
          w = $urandom_range(0, 99);
          if (deep) r = feed_req(term[0]);
          else if (w < 85) r = feed_req(term[$urandom_range(0, 3)]);
          else if (w < 95) r = feed_req($urandom_range(0, SYMBOLS - 1));
          else r = noise_req();
          send(r, 1'b0, '0);
          steps++;
        end
        repeat ($urandom_range(0, 2)) send(feed_req($urandom_range(0, SYMBOLS - 1)), 1'b0, '0);
      end
    end

    // Drain: wait for every result, then a little longer for stray ones.
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      fail_count += pending_results.size();
      $display("%0d results never arrived", pending_results.size());
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/lrpe_pkg.sv
rtl/lrpe_ctrl.sv
rtl/lrpe_dpath.sv
rtl/lr_table_parse_engine_core.sv
rtl/lrpe_checker.sv
bench/tb_top.sv
